// ===== rtl/izc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// izc_pkg
// Shared constants, register map and types of the centered integer zoom
// scaler.
// ----------------------------------------------------------------------------
package izc_pkg;

    localparam int MAX_SRC_DIM = 1024;
    localparam int MAX_DST_DIM = 2048;
    localparam int MAX_ZOOM    = 16;

    // register and field widths
    localparam int ZOOM_W = 5;
    localparam int SW_W   = 11;
    localparam int DW_W   = 12;
    localparam int RGB_W  = 24;
    localparam int DIDX_W = 22;
    localparam int SIDX_W = 20;

    // internal widths
    localparam int SCOL_W = $clog2(MAX_SRC_DIM);
    localparam int DCOL_W = $clog2(MAX_DST_DIM);
    localparam int DLEN_W = DCOL_W + 1;
    localparam int REP_W  = $clog2(MAX_ZOOM);
    localparam int FULL_W = $clog2(MAX_SRC_DIM * MAX_ZOOM + 1);
    localparam int GEO_W  = (FULL_W > DW_W) ? FULL_W : DW_W;

    // output tdata layout, padded to whole bytes
    localparam int ODATA_RAW = DIDX_W + RGB_W + SIDX_W;
    localparam int ODATA_W   = ((ODATA_RAW + 7) / 8) * 8;
    localparam int IDATA_W   = ((RGB_W + 7) / 8) * 8;

    // register map
    localparam int PADDR_W  = 5;
    localparam logic [2:0] REG_ZOOM  = 3'd0;
    localparam logic [2:0] REG_SRC_W = 3'd1;
    localparam logic [2:0] REG_SRC_H = 3'd2;
    localparam logic [2:0] REG_DST_W = 3'd3;
    localparam logic [2:0] REG_DST_H = 3'd4;

    // cycles the derived geometry needs after a register write
    localparam int SETTLE     = 3;
    localparam int SETTLE_W   = $clog2(SETTLE + 1);

    typedef struct packed {
        logic                busy;     // geometry not yet settled
        logic                restart;  // register written, restart the frame
        logic [ZOOM_W-1:0]   zoom;
        logic [SW_W-1:0]     src_w;
        logic [DW_W-1:0]     dst_w;
        logic [DLEN_W-1:0]   area_w;
        logic [DLEN_W-1:0]   area_h;
        logic [DCOL_W-1:0]   off_x;
        logic [DIDX_W-1:0]   base0;    // row offset times frame width
    } t_geom;

endpackage : izc_pkg
`default_nettype wire

// ===== rtl/integer_zoom_centered_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_zoom_centered_scaler
// Nearest-neighbor integer upscaler that places the zoomed picture in the
// middle of the destination frame, clipped to the frame where it is larger.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per destination pixel of the zoomed area:
//   the source pixel found at the source index announced by the previous
//   result (index 0 after reset or after a write to a mapped register).
//   m_axis returns the destination index, the pixel, the next source index
//   to fetch, and tlast on the final pixel of the area; after it the frame
//   starts again from the top left. Border pixels are never produced.
//   A result appears in the cycle after its request is taken; throughput is
//   one pixel per clock while m_axis keeps up and the geometry is settled,
//   set by the position counters and the result register.
//   When m_axis stalls, the held result stays put and s_axis_tready drops
//   only once the result register is full and not being drained.
//   After reset and each mapped register write s_axis_tready stays low while
//   clamped sizes, offsets and first row base pass through their pipeline.
//   Registers must be written only while no pixel is in flight; not enforced.
// ----------------------------------------------------------------------------
module integer_zoom_centered_scaler
    import izc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // APB-style register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // source pixel requests
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [IDATA_W-1:0] s_axis_tdata,   // [23:0] src_rgb
    // destination pixel results
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [ODATA_W-1:0]      m_axis_tdata,   // [21:0] dst_index,
                                                    // [45:22] dst_rgb,
                                                    // [65:46] next_src_index,
                                                    // [71:66] zero
    output logic                    m_axis_tlast    // frame_done
);

    t_geom             geom;
    logic [DIDX_W-1:0] dst_index;
    logic [RGB_W-1:0]  dst_rgb;
    logic [SIDX_W-1:0] next_src;

    izc_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    izc_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_rgb    (s_axis_tdata[RGB_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dst_index (dst_index),
        .o_dst_rgb   (dst_rgb),
        .o_next_src  (next_src),
        .o_done      (m_axis_tlast)
    );

    assign m_axis_tdata = ODATA_W'({next_src, dst_rgb, dst_index});

    // the frame wraps to source index 0 on its last pixel
    a_last_wraps_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> next_src == '0)
        else $error("next source index not zero on last pixel");

    // a register write blocks requests while the geometry settles
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geom.restart |=> !s_axis_tready)
        else $error("request taken right after register write");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geom.busy |-> !s_axis_tready)
        else $error("request taken while geometry settles");

    // every request yields a result in the next cycle
    a_request_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("request produced no result");

endmodule : integer_zoom_centered_scaler
`default_nettype wire

// ===== rtl/izc_geom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// izc_geom
// Configuration registers on an APB-style port and a three-stage pipeline
// that derives the clamped geometry: area size, centering offsets and the
// first row base of the destination frame.
// ----------------------------------------------------------------------------
module izc_geom
    import izc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output t_geom                   o_geom
);

    logic [ZOOM_W-1:0] r_zoom;
    logic [SW_W-1:0]   r_src_w;
    logic [SW_W-1:0]   r_src_h;
    logic [DW_W-1:0]   r_dst_w;
    logic [DW_W-1:0]   r_dst_h;

    logic              wr_req;
    logic              wr_hit;
    logic [2:0]        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_req  = psel && penable && pwrite;
    assign wr_hit  = wr_req && (reg_sel inside {REG_ZOOM, REG_SRC_W, REG_SRC_H,
                                                REG_DST_W, REG_DST_H});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom  <= ZOOM_W'(1);
            r_src_w <= SW_W'(240);
            r_src_h <= SW_W'(160);
            r_dst_w <= DW_W'(240);
            r_dst_h <= DW_W'(160);
        end else if (wr_req) begin
            case (reg_sel)
                REG_ZOOM:  r_zoom  <= pwdata[ZOOM_W-1:0];
                REG_SRC_W: r_src_w <= pwdata[SW_W-1:0];
                REG_SRC_H: r_src_h <= pwdata[SW_W-1:0];
                REG_DST_W: r_dst_w <= pwdata[DW_W-1:0];
                REG_DST_H: r_dst_h <= pwdata[DW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ZOOM:  prdata = 32'(r_zoom);
            REG_SRC_W: prdata = 32'(r_src_w);
            REG_SRC_H: prdata = 32'(r_src_h);
            REG_DST_W: prdata = 32'(r_dst_w);
            REG_DST_H: prdata = 32'(r_dst_h);
            default:   prdata = 32'd0;
        endcase
    end

    // stage A: clamp and form the full zoomed sizes
    logic [ZOOM_W-1:0] r_za;
    logic [SW_W-1:0]   r_swa;
    logic [DW_W-1:0]   r_dwa;
    logic [DW_W-1:0]   r_dha;
    logic [FULL_W-1:0] r_fullw;
    logic [FULL_W-1:0] r_fullh;
    logic [ZOOM_W-1:0] n_za;
    logic [SW_W-1:0]   n_swa;
    logic [SW_W-1:0]   n_sha;

    always_comb begin
        if (r_zoom == '0)                    n_za = ZOOM_W'(1);
        else if (32'(r_zoom) > MAX_ZOOM)     n_za = ZOOM_W'(MAX_ZOOM);
        else                                 n_za = r_zoom;
        if (r_src_w == '0)                   n_swa = SW_W'(1);
        else if (32'(r_src_w) > MAX_SRC_DIM) n_swa = SW_W'(MAX_SRC_DIM);
        else                                 n_swa = r_src_w;
        if (r_src_h == '0)                   n_sha = SW_W'(1);
        else if (32'(r_src_h) > MAX_SRC_DIM) n_sha = SW_W'(MAX_SRC_DIM);
        else                                 n_sha = r_src_h;
    end

    always_ff @(posedge i_clk) begin
        r_za    <= n_za;
        r_swa   <= n_swa;
        r_fullw <= FULL_W'(n_swa * n_za);
        r_fullh <= FULL_W'(n_sha * n_za);
        if (r_dst_w == '0)                   r_dwa <= DW_W'(1);
        else if (32'(r_dst_w) > MAX_DST_DIM) r_dwa <= DW_W'(MAX_DST_DIM);
        else                                 r_dwa <= r_dst_w;
        if (r_dst_h == '0)                   r_dha <= DW_W'(1);
        else if (32'(r_dst_h) > MAX_DST_DIM) r_dha <= DW_W'(MAX_DST_DIM);
        else                                 r_dha <= r_dst_h;
    end

    // stage B: clip the area to the frame and center it
    logic [GEO_W-1:0]  fw_e;
    logic [GEO_W-1:0]  fh_e;
    logic [GEO_W-1:0]  dw_e;
    logic [GEO_W-1:0]  dh_e;
    logic [DLEN_W-1:0] r_aw;
    logic [DLEN_W-1:0] r_ah;
    logic [DCOL_W-1:0] r_ox;
    logic [DCOL_W-1:0] r_oy;

    assign fw_e = GEO_W'(r_fullw);
    assign fh_e = GEO_W'(r_fullh);
    assign dw_e = GEO_W'(r_dwa);
    assign dh_e = GEO_W'(r_dha);

    always_ff @(posedge i_clk) begin
        r_aw <= (fw_e < dw_e) ? DLEN_W'(fw_e) : DLEN_W'(dw_e);
        r_ah <= (fh_e < dh_e) ? DLEN_W'(fh_e) : DLEN_W'(dh_e);
        r_ox <= (dw_e >= fw_e) ? DCOL_W'((dw_e - fw_e) >> 1) : '0;
        r_oy <= (dh_e >= fh_e) ? DCOL_W'((dh_e - fh_e) >> 1) : '0;
    end

    // stage C: base index of the first area row
    logic [DIDX_W-1:0] r_base0;

    always_ff @(posedge i_clk) begin
        r_base0 <= DIDX_W'(r_oy * r_dwa);
    end

    // hold off requests until the pipeline has caught up with a write
    logic [SETTLE_W-1:0] r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_W'(SETTLE);
        end else if (wr_hit) begin
            r_settle <= SETTLE_W'(SETTLE);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    always_comb begin
        o_geom.busy    = (r_settle != '0);
        o_geom.restart = wr_hit;
        o_geom.zoom    = r_za;
        o_geom.src_w   = r_swa;
        o_geom.dst_w   = r_dwa;
        o_geom.area_w  = r_aw;
        o_geom.area_h  = r_ah;
        o_geom.off_x   = r_ox;
        o_geom.base0   = r_base0;
    end

endmodule : izc_geom
`default_nettype wire

// ===== rtl/izc_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// izc_step
// Position counters of the zoomed area and the result register. One request
// advances the counters and loads one result; row bases are kept as running
// sums so no multiply sits in the per-pixel path.
// ----------------------------------------------------------------------------
module izc_step
    import izc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_geom            i_geom,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [RGB_W-1:0] i_in_rgb,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [DIDX_W-1:0]     o_dst_index,
    output logic [RGB_W-1:0]      o_dst_rgb,
    output logic [SIDX_W-1:0]     o_next_src,
    output logic                  o_done
);

    logic              r_frame_start;
    logic [DCOL_W-1:0] r_dcol;
    logic [DCOL_W-1:0] r_drow;
    logic [SCOL_W-1:0] r_scol;
    logic [SCOL_W-1:0] r_srow;
    logic [REP_W-1:0]  r_crep;
    logic [REP_W-1:0]  r_rrep;
    logic [DIDX_W-1:0] r_dbase;
    logic [SIDX_W-1:0] r_sbase;

    logic              r_out_valid;
    logic [DIDX_W-1:0] r_dst_index;
    logic [RGB_W-1:0]  r_dst_rgb;
    logic [SIDX_W-1:0] r_next_src;
    logic              r_done;

    logic              accept;

    // current position, reloaded at the start of a frame
    logic [DCOL_W-1:0] c_dcol;
    logic [DCOL_W-1:0] c_drow;
    logic [SCOL_W-1:0] c_scol;
    logic [SCOL_W-1:0] c_srow;
    logic [REP_W-1:0]  c_crep;
    logic [REP_W-1:0]  c_rrep;
    logic [DIDX_W-1:0] c_dbase;
    logic [SIDX_W-1:0] c_sbase;

    logic [DLEN_W-1:0] col_inc;
    logic [DLEN_W-1:0] row_inc;
    logic [ZOOM_W-1:0] crep_inc;
    logic [ZOOM_W-1:0] rrep_inc;
    logic              col_wrap;
    logic              row_wrap;
    logic              crep_hit;
    logic              rrep_hit;

    logic [DCOL_W-1:0] n_dcol;
    logic [DCOL_W-1:0] n_drow;
    logic [SCOL_W-1:0] n_scol;
    logic [SCOL_W-1:0] n_srow;
    logic [REP_W-1:0]  n_crep;
    logic [REP_W-1:0]  n_rrep;
    logic [DIDX_W-1:0] n_dbase;
    logic [SIDX_W-1:0] n_sbase;
    logic              n_done;
    logic [DIDX_W-1:0] n_dst_index;
    logic [SIDX_W-1:0] n_next_src;

    assign o_in_ready = !i_geom.busy && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        c_dcol  = r_frame_start ? '0 : r_dcol;
        c_drow  = r_frame_start ? '0 : r_drow;
        c_scol  = r_frame_start ? '0 : r_scol;
        c_srow  = r_frame_start ? '0 : r_srow;
        c_crep  = r_frame_start ? '0 : r_crep;
        c_rrep  = r_frame_start ? '0 : r_rrep;
        c_dbase = r_frame_start ? i_geom.base0 : r_dbase;
        c_sbase = r_frame_start ? '0 : r_sbase;

        col_inc  = DLEN_W'(c_dcol) + DLEN_W'(1);
        row_inc  = DLEN_W'(c_drow) + DLEN_W'(1);
        crep_inc = ZOOM_W'(c_crep) + ZOOM_W'(1);
        rrep_inc = ZOOM_W'(c_rrep) + ZOOM_W'(1);
        col_wrap = (col_inc >= i_geom.area_w);
        row_wrap = (row_inc >= i_geom.area_h);
        crep_hit = (crep_inc >= i_geom.zoom);
        rrep_hit = (rrep_inc >= i_geom.zoom);

        n_dst_index = c_dbase + DIDX_W'(i_geom.off_x) + DIDX_W'(c_dcol);

        n_drow  = c_drow;
        n_srow  = c_srow;
        n_rrep  = c_rrep;
        n_dbase = c_dbase;
        n_sbase = c_sbase;
        n_done  = 1'b0;
        if (!col_wrap) begin
            n_dcol = DCOL_W'(col_inc);
            n_crep = crep_hit ? '0 : REP_W'(crep_inc);
            n_scol = crep_hit ? c_scol + SCOL_W'(1) : c_scol;
        end else begin
            n_dcol = '0;
            n_crep = '0;
            n_scol = '0;
            if (row_wrap) begin
                // last pixel of the area: back to the top left
                n_done  = 1'b1;
                n_drow  = '0;
                n_srow  = '0;
                n_rrep  = '0;
                n_dbase = i_geom.base0;
                n_sbase = '0;
            end else begin
                n_drow  = DCOL_W'(row_inc);
                n_dbase = c_dbase + DIDX_W'(i_geom.dst_w);
                if (rrep_hit) begin
                    n_rrep  = '0;
                    n_srow  = c_srow + SCOL_W'(1);
                    n_sbase = c_sbase + SIDX_W'(i_geom.src_w);
                end else begin
                    n_rrep = REP_W'(rrep_inc);
                end
            end
        end

        n_next_src = n_sbase + SIDX_W'(n_scol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
            r_dcol        <= '0;
            r_drow        <= '0;
            r_scol        <= '0;
            r_srow        <= '0;
            r_crep        <= '0;
            r_rrep        <= '0;
            r_dbase       <= '0;
            r_sbase       <= '0;
        end else if (i_geom.restart) begin
            r_frame_start <= 1'b1;
        end else if (accept) begin
            r_frame_start <= 1'b0;
            r_dcol        <= n_dcol;
            r_drow        <= n_drow;
            r_scol        <= n_scol;
            r_srow        <= n_srow;
            r_crep        <= n_crep;
            r_rrep        <= n_rrep;
            r_dbase       <= n_dbase;
            r_sbase       <= n_sbase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dst_index <= n_dst_index;
            r_dst_rgb   <= i_in_rgb;
            r_next_src  <= n_next_src;
            r_done      <= n_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dst_index = r_dst_index;
    assign o_dst_rgb   = r_dst_rgb;
    assign o_next_src  = r_next_src;
    assign o_done      = r_done;

endmodule : izc_step
`default_nettype wire

// ===== tb/integer_zoom_centered_scaler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_zoom_centered_scaler_test
// Self-checking bench for the centered integer zoom scaler. Source pixels go
// in on s_axis. A local model of the zoom counters predicts every destination
// write, and each result on m_axis is checked against it. The geometry is
// reprogrammed over APB between phases, including out-of-range values and
// clipped frames. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module integer_zoom_centered_scaler_test;
    import izc_pkg::*;

    localparam int         ITEMS_TOTAL = 1350;
    localparam int         STALL_LIMIT = 1000;
    localparam int         LONG_HOLD   = 64;
    localparam int         MAX_REPORTS = 10;
    localparam int         CALM_FROM   = 700;
    localparam int         CALM_TO     = 900;
    localparam logic [2:0] REG_SPARE   = 3'd5;

    typedef struct packed {
        logic [DIDX_W-1:0] dst_index;
        logic [RGB_W-1:0]  dst_rgb;
        logic [SIDX_W-1:0] next_src_index;
        logic              frame_done;
    } t_dest_write;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IDATA_W-1:0] s_axis_tdata  = '0;    // [23:0] src_rgb
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ODATA_W-1:0] m_axis_tdata;          // [21:0] dst_index, [45:22] dst_rgb,
                                               // [65:46] next_src_index, [71:66] zero
    logic               m_axis_tlast;          // frame_done

    // model of the programmed geometry and the zoom counters
    int unsigned cfg_zoom  = 1;
    int unsigned cfg_src_w = 240;
    int unsigned cfg_src_h = 160;
    int unsigned cfg_dst_w = 240;
    int unsigned cfg_dst_h = 160;
    int unsigned pos_dcol  = 0;
    int unsigned pos_drow  = 0;
    int unsigned pos_scol  = 0;
    int unsigned pos_srow  = 0;
    int unsigned rep_col   = 0;
    int unsigned rep_row   = 0;
    bit          restart_pending = 1'b1;

    logic [RGB_W-1:0] pixel_q[$];
    t_dest_write      dest_expect_q[$];
    int unsigned      items_accepted = 0;
    int unsigned      fail_count     = 0;
    int unsigned      stall_cycles   = 0;
    int unsigned      hold_left      = 0;
    bit               src_taken      = 1'b0;
    bit               long_hold_done = 1'b0;
    logic             calm;

    assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

    integer_zoom_centered_scaler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void home_position();
        pos_dcol = 0;
        pos_drow = 0;
        pos_scol = 0;
        pos_srow = 0;
        rep_col  = 0;
        rep_row  = 0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_ZOOM:  cfg_zoom  = val[ZOOM_W-1:0];
            REG_SRC_W: cfg_src_w = val[SW_W-1:0];
            REG_SRC_H: cfg_src_h = val[SW_W-1:0];
            REG_DST_W: cfg_dst_w = val[DW_W-1:0];
            REG_DST_H: cfg_dst_h = val[DW_W-1:0];
            default:   return;
        endcase
        restart_pending = 1'b1;
    endfunction

    // advance the zoom counters by one destination pixel
    function automatic t_dest_write scale_pixel(input logic [RGB_W-1:0] rgb);
        int unsigned z, sw, sh, dw, dh, full_w, full_h, aw, ah, ox, oy, didx;
        t_dest_write r;
        z      = clamp_size(cfg_zoom, MAX_ZOOM);
        sw     = clamp_size(cfg_src_w, MAX_SRC_DIM);
        sh     = clamp_size(cfg_src_h, MAX_SRC_DIM);
        dw     = clamp_size(cfg_dst_w, MAX_DST_DIM);
        dh     = clamp_size(cfg_dst_h, MAX_DST_DIM);
        full_w = sw * z;
        full_h = sh * z;
        aw     = (full_w < dw) ? full_w : dw;
        ah     = (full_h < dh) ? full_h : dh;
        ox     = (dw >= full_w) ? (dw - full_w) / 2 : 0;
        oy     = (dh >= full_h) ? (dh - full_h) / 2 : 0;
        if (restart_pending) begin
            home_position();
            restart_pending = 1'b0;
        end
        didx = (oy + pos_drow) * dw + ox + pos_dcol;
        r.frame_done = 1'b0;
        rep_col++;
        if (rep_col >= z) begin
            rep_col = 0;
            pos_scol++;
        end
        pos_dcol++;
        if (pos_dcol >= aw) begin
            pos_dcol = 0;
            pos_scol = 0;
            rep_col  = 0;
            rep_row++;
            if (rep_row >= z) begin
                rep_row = 0;
                pos_srow++;
            end
            pos_drow++;
            if (pos_drow >= ah) begin
                r.frame_done = 1'b1;
                home_position();
            end
        end
        if (pos_scol >= sw) pos_scol = sw - 1;
        if (pos_srow >= sh) pos_srow = sh - 1;
        r.dst_index      = DIDX_W'(didx);
        r.dst_rgb        = rgb;
        r.next_src_index = SIDX_W'(pos_srow * sw + pos_scol);
        return r;
    endfunction

    // set random bits above the register width now and then
    function automatic logic [31:0] with_noise(input int unsigned v, input int w);
        if ($urandom_range(0, 3) == 0) return v | ($urandom() << w);
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned z, sw, sh, dw, dh);
        write_reg(REG_ZOOM,  with_noise(z,  ZOOM_W));
        write_reg(REG_SRC_W, with_noise(sw, SW_W));
        write_reg(REG_SRC_H, with_noise(sh, SW_W));
        write_reg(REG_DST_W, with_noise(dw, DW_W));
        write_reg(REG_DST_H, with_noise(dh, DW_W));
    endtask

    // hold until every request is in and every result is out, then let settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || dest_expect_q.size() != 0);
        repeat (SETTLE + 2) @(posedge i_clk);
    endtask

    // source side
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || src_taken) begin
            if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IDATA_W'(pixel_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side: one long hold-off once the source has plenty queued
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!long_hold_done && pixel_q.size() >= 40) begin
            m_axis_tready  <= 1'b0;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else begin
            m_axis_tready <= calm || $urandom_range(0, 99) >= 10;
        end
    end

    always @(posedge i_clk) begin
        t_dest_write got, want;
        src_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            // check before predicting: a request never matches its own cycle
            if (m_axis_tvalid && m_axis_tready) begin
                got.dst_index      = m_axis_tdata[DIDX_W-1:0];
                got.dst_rgb        = m_axis_tdata[DIDX_W +: RGB_W];
                got.next_src_index = m_axis_tdata[DIDX_W+RGB_W +: SIDX_W];
                got.frame_done     = m_axis_tlast;
                if (dest_expect_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: result with nothing pending:", $realtime,
                                 " idx %h rgb %h next %h last %b",
                                 got.dst_index, got.dst_rgb, got.next_src_index,
                                 got.frame_done);
                    fail_count++;
                end else begin
                    want = dest_expect_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: mismatch:", $realtime,
                                     " expected idx %h rgb %h next %h last %b,",
                                     want.dst_index, want.dst_rgb,
                                     want.next_src_index, want.frame_done,
                                     " got idx %h rgb %h next %h last %b",
                                     got.dst_index, got.dst_rgb,
                                     got.next_src_index, got.frame_done);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                dest_expect_q.push_back(scale_pixel(s_axis_tdata[RGB_W-1:0]));
                items_accepted <= items_accepted + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pixel_q.size() == 0 && !s_axis_tvalid && dest_expect_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned z, sw, sh, dw, dh, full_w, full_h, n, half, pushed;
        int unsigned extreme_cfg [7][6];
        // zoom, src w, src h, dst w, dst h, pixels
        extreme_cfg = '{'{16,    1,    1,   20,   18, 260},
                        '{ 0,    5,    4,    5,    4,  45},
                        '{31,    1,    2,    0,   40,  70},
                        '{ 3,    0,    0, 4095,    5,  30},
                        '{ 1, 2047, 2047, 2048, 4095,  60},
                        '{ 1,    1,    3, 2048, 2048,  10},
                        '{ 4,    3,    3,   10,    6,  70}};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry with extreme pixel values
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hFFFFFF);
        pixel_q.push_back(24'h555555);
        pixel_q.push_back(24'hAAAAAA);
        wait_drained();
        // small centered frame, then an unmapped write in mid-frame
        set_geometry(2, 3, 2, 10, 7);
        repeat (20) pixel_q.push_back(RGB_W'($urandom()));
        wait_drained();
        write_reg(REG_SPARE, $urandom());
        repeat (6) pixel_q.push_back(RGB_W'($urandom()));
        pushed = 30;

        foreach (extreme_cfg[k]) begin
            wait_drained();
            set_geometry(extreme_cfg[k][0], extreme_cfg[k][1], extreme_cfg[k][2],
                         extreme_cfg[k][3], extreme_cfg[k][4]);
            n = extreme_cfg[k][5];
            if (k == 0) begin
                // pause the source until the block empties, mid-frame
                half = n / 2;
                repeat (half) pixel_q.push_back(RGB_W'($urandom()));
                wait_drained();
                n = n - half;
            end
            repeat (n) pixel_q.push_back(RGB_W'($urandom()));
            pushed += extreme_cfg[k][5];
        end

        while (pushed < ITEMS_TOTAL) begin
            z      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            sw     = $urandom_range(1, 6);
            sh     = $urandom_range(1, 5);
            full_w = sw * clamp_size(z, MAX_ZOOM);
            full_h = sh * clamp_size(z, MAX_ZOOM);
            dw     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full_w)
                                                 : full_w + $urandom_range(0, 7);
            dh     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full_h)
                                                 : full_h + $urandom_range(0, 7);
            n      = $urandom_range(15, 60);
            wait_drained();
            set_geometry(z, sw, sh, dw, dh);
            if ($urandom_range(0, 3) == 0) begin
                half = n / 2;
                repeat (half) pixel_q.push_back(RGB_W'($urandom()));
                wait_drained();
                repeat (n - half) pixel_q.push_back(RGB_W'($urandom()));
            end else begin
                repeat (n) pixel_q.push_back(RGB_W'($urandom()));
            end
            pushed += n;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
